FILE: design/ymcr_pkg.sv
// Shared types, constants and functions of the YMODEM-CRC receiver.
package ymcr_pkg;

    localparam int unsigned SHORT_PAYLOAD = 128;
    localparam int unsigned LONG_PAYLOAD = 1024;
    localparam int unsigned SIZE_DIGITS_MAX_DEF = 16;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [31:0] SIZE_LIMIT_RST = 32'd65536;
    localparam logic [31:0] FLASH_BASE_RST = 32'd0;
    localparam logic [7:0] ERROR_LIMIT_RST = 8'd5;

    localparam logic [1:0] CFG_SIZE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_FLASH_BASE = 2'd1;
    localparam logic [1:0] CFG_ERROR_LIMIT = 2'd2;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TIMEOUT = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_ETX = 8'h03;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CA = 8'h18;
    localparam logic [7:0] B_C = 8'h43;
    localparam logic [7:0] B_AB1 = 8'h41;
    localparam logic [7:0] B_AB2 = 8'h61;

    localparam logic [2:0] K_SEND = 3'd0;
    localparam logic [2:0] K_STAGE = 3'd1;
    localparam logic [2:0] K_COMMIT = 3'd2;
    localparam logic [2:0] K_ERASE = 3'd3;
    localparam logic [2:0] K_END = 3'd4;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_CANCEL = 3'd1;
    localparam logic [2:0] ST_ABORT = 3'd2;
    localparam logic [2:0] ST_LARGE = 3'd3;
    localparam logic [2:0] ST_ERRORS = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_CA2,
        PH_BODY
    } t_phase;

    // Action code handed from the front part to the back part.
    typedef enum logic [3:0] {
        A_NONE,
        A_START,     // C
        A_FAIL,      // C
        A_EOT,       // ACK, C
        A_CA2,       // ACK, end(cancel)
        A_ABORT,     // CA CA, end(abort)
        A_STAGE,     // stage byte
        A_NAK,       // NAK
        A_EMPTY,     // ACK, end(done, size)
        A_LARGE,     // CA CA, end(large, size)
        A_ERASE,     // erase, ACK, C
        A_COMMIT,    // commit, ACK
        A_ERRORS     // CA CA, end(errors)
    } t_action;

    typedef struct packed {
        t_action act;
        logic [7:0] data;
        logic [31:0] addr;
        logic [31:0] amt;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic [31:0] address;
        logic [31:0] amount;
        logic [2:0] status;
        logic last;
    } t_res;

    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: design/ymcr_front.sv
// Front part: deframes the byte stream, checks packets, tracks errors and classifies actions.
module ymcr_front import ymcr_pkg::*; #(
    parameter int unsigned SIZE_DIGITS_MAX = SIZE_DIGITS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_size_limit,
    input  logic [31:0] i_flash_base,
    input  logic [7:0]  i_error_limit,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);

    localparam int unsigned DW = $clog2(SIZE_DIGITS_MAX + 1);

    t_phase r_phase, n_phase;
    logic [10:0] r_idx, n_idx;
    logic r_long, n_long;
    logic [7:0] r_seq, n_seq;
    logic r_seq_ok, n_seq_ok;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_crc_rx, n_crc_rx;
    logic [7:0] r_pkts, n_pkts;
    logic r_first_done, n_first_done;
    logic [31:0] r_waddr, n_waddr;
    logic [31:0] r_fsize, n_fsize;
    logic [31:0] r_swork, n_swork;
    logic [1:0] r_spp, n_spp;
    logic [DW-1:0] r_sdig, n_sdig;
    logic r_nonempty, n_nonempty;
    logic [7:0] r_errs, n_errs;
    logic r_started, n_started;
    t_cmd cmd;
    logic [10:0] len;
    logic [10:0] pos;
    logic [35:0] prod;
    logic [31:0] sat;
    logic [7:0] errs_inc;
    logic err_over;
    logic fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx <= '0;
            r_long <= 1'b0;
            r_seq <= '0;
            r_seq_ok <= 1'b0;
            r_crc <= '0;
            r_crc_rx <= '0;
            r_pkts <= '0;
            r_first_done <= 1'b0;
            r_waddr <= '0;
            r_fsize <= '0;
            r_swork <= '0;
            r_spp <= '0;
            r_sdig <= '0;
            r_nonempty <= 1'b0;
            r_errs <= '0;
            r_started <= 1'b0;
            o_cmd_valid <= 1'b0;
            o_cmd <= '0;
        end else begin
            o_cmd_valid <= 1'b0;
            if (i_valid) begin
                r_phase <= n_phase;
                r_idx <= n_idx;
                r_long <= n_long;
                r_seq <= n_seq;
                r_seq_ok <= n_seq_ok;
                r_crc <= n_crc;
                r_crc_rx <= n_crc_rx;
                r_pkts <= n_pkts;
                r_first_done <= n_first_done;
                r_waddr <= n_waddr;
                r_fsize <= n_fsize;
                r_swork <= n_swork;
                r_spp <= n_spp;
                r_sdig <= n_sdig;
                r_nonempty <= n_nonempty;
                r_errs <= n_errs;
                r_started <= n_started;
                o_cmd_valid <= (cmd.act != A_NONE);
                o_cmd <= cmd;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx = r_idx;
        n_long = r_long;
        n_seq = r_seq;
        n_seq_ok = r_seq_ok;
        n_crc = r_crc;
        n_crc_rx = r_crc_rx;
        n_pkts = r_pkts;
        n_first_done = r_first_done;
        n_waddr = r_waddr;
        n_fsize = r_fsize;
        n_swork = r_swork;
        n_spp = r_spp;
        n_sdig = r_sdig;
        n_nonempty = r_nonempty;
        n_errs = r_errs;
        n_started = r_started;
        fail = 1'b0;
        cmd = '0;
        cmd.act = A_NONE;
        len = r_long ? 11'(LONG_PAYLOAD) : 11'(SHORT_PAYLOAD);
        pos = r_idx - 11'd2;
        prod = {4'd0, r_swork} * 36'd10 + {28'd0, i_rx_byte - 8'h30};
        sat = (prod[35:32] != 4'd0) ? 32'hffff_ffff : prod[31:0];
        // errors count only once the session has begun, saturating
        errs_inc = (r_started && r_errs != 8'hff) ? r_errs + 8'd1 : r_errs;
        err_over = (errs_inc > i_error_limit);
        case (i_req_type)
            REQ_START: begin
                n_phase = PH_HEAD;
                n_idx = '0;
                n_long = 1'b0;
                n_seq = '0;
                n_seq_ok = 1'b0;
                n_crc = '0;
                n_crc_rx = '0;
                n_pkts = '0;
                n_first_done = 1'b0;
                n_waddr = i_flash_base;
                n_fsize = '0;
                n_swork = '0;
                n_spp = '0;
                n_sdig = '0;
                n_nonempty = 1'b0;
                n_errs = '0;
                n_started = 1'b0;
                cmd.act = A_START;
            end
            REQ_TIMEOUT: begin
                if (r_phase != PH_IDLE) fail = 1'b1;
            end
            REQ_BYTE: begin
                case (r_phase)
                    PH_HEAD: begin
                        if (i_rx_byte == B_SOH || i_rx_byte == B_STX) begin
                            n_long = (i_rx_byte == B_STX);
                            n_idx = '0;
                            n_crc = '0;
                            n_crc_rx = '0;
                            n_seq_ok = 1'b0;
                            n_spp = '0;
                            n_sdig = '0;
                            n_swork = '0;
                            n_nonempty = 1'b0;
                            n_phase = PH_BODY;
                        end else if (i_rx_byte == B_EOT) begin
                            cmd.act = A_EOT;
                            n_errs = '0;
                            n_pkts = '0;
                            n_first_done = 1'b0;
                        end else if (i_rx_byte == B_CA) begin
                            n_phase = PH_CA2;
                        end else if (i_rx_byte == B_ETX || i_rx_byte == B_AB1
                                     || i_rx_byte == B_AB2) begin
                            cmd.act = A_ABORT;
                            n_phase = PH_IDLE;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_CA2: begin
                        if (i_rx_byte == B_CA) begin
                            cmd.act = A_CA2;
                            n_phase = PH_IDLE;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        n_idx = r_idx + 11'd1;
                        if (r_idx == 11'd0) begin
                            n_seq = i_rx_byte;
                        end else if (r_idx == 11'd1) begin
                            n_seq_ok = (i_rx_byte == ~r_seq);
                        end else if (r_idx < len + 11'd2) begin
                            n_crc = crc_update(r_crc, i_rx_byte);
                            if (r_first_done) begin
                                cmd.act = A_STAGE;
                                cmd.data = i_rx_byte;
                                cmd.addr = r_waddr + {21'd0, pos};
                            end else begin
                                if (pos == 11'd0) n_nonempty = (i_rx_byte != 8'd0);
                                if (r_spp == 2'd0) begin
                                    if (i_rx_byte == 8'd0) n_spp = 2'd1;
                                end else if (r_spp == 2'd1) begin
                                    if (i_rx_byte == 8'h20
                                        || r_sdig >= DW'(SIZE_DIGITS_MAX)
                                        || i_rx_byte < 8'h30 || i_rx_byte > 8'h39) begin
                                        n_spp = 2'd2;
                                    end else begin
                                        n_sdig = r_sdig + 1'b1;
                                        n_swork = sat;
                                    end
                                end
                            end
                        end else if (r_idx == len + 11'd2) begin
                            n_crc_rx = {i_rx_byte, 8'h00};
                        end else begin
                            n_idx = r_idx;
                            n_crc_rx = {r_crc_rx[15:8], i_rx_byte};
                            n_phase = PH_HEAD;
                            if (!r_seq_ok || r_crc != {r_crc_rx[15:8], i_rx_byte}) begin
                                fail = 1'b1;
                            end else begin
                                n_errs = '0;
                                if (r_seq != r_pkts) begin
                                    cmd.act = A_NAK;
                                end else if (!r_first_done) begin
                                    if (!r_nonempty) begin
                                        cmd.act = A_EMPTY;
                                        cmd.amt = r_fsize;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_fsize = r_swork;
                                        cmd.amt = r_swork;
                                        if (r_swork > i_size_limit) begin
                                            cmd.act = A_LARGE;
                                            n_phase = PH_IDLE;
                                        end else begin
                                            cmd.act = A_ERASE;
                                            cmd.addr = r_waddr;
                                            n_first_done = 1'b1;
                                            n_pkts = r_pkts + 8'd1;
                                            n_started = 1'b1;
                                        end
                                    end
                                end else begin
                                    cmd.act = A_COMMIT;
                                    cmd.addr = r_waddr;
                                    cmd.amt = {21'd0, len};
                                    n_waddr = r_waddr + {21'd0, len};
                                    n_pkts = r_pkts + 8'd1;
                                    n_started = 1'b1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        // count the error and either ask again or give up on the session
        if (fail) begin
            n_errs = errs_inc;
            if (err_over) begin
                cmd.act = A_ERRORS;
                n_phase = PH_IDLE;
            end else begin
                cmd.act = A_FAIL;
                n_phase = PH_HEAD;
            end
        end
    end

endmodule

FILE: design/ymcr_queue.sv
// Short command queue between the front and back parts.
module ymcr_queue import ymcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_empty,
    output logic [$clog2(QUEUE_DEPTH):0] o_count,
    output t_cmd o_data
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    t_cmd r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{AW{1'b0}}, i_push} - {{AW{1'b0}}, i_pop};
        end
    end

endmodule

FILE: design/ymcr_back.sv
// Back part: expands commands into result items.
module ymcr_back import ymcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_res_valid,
    output t_res       o_res,
    input  logic       i_res_pop
);

    logic [1:0] r_sub, n_sub;
    logic r_vld;
    t_res r_res;
    t_res res;
    logic last;
    logic load;

    assign load = !r_vld || i_res_pop;
    assign o_res_valid = r_vld;
    assign o_res = r_res;

    always_comb begin
        res = '0;
        last = 1'b0;
        case (i_cmd.act)
            A_START, A_FAIL: begin
                res.kind = K_SEND; res.tx_byte = B_C; last = 1'b1;
            end
            A_EOT: begin
                res.kind = K_SEND;
                res.tx_byte = (r_sub == 2'd0) ? B_ACK : B_C;
                last = (r_sub == 2'd1);
            end
            A_CA2: begin
                if (r_sub == 2'd0) begin
                    res.kind = K_SEND; res.tx_byte = B_ACK;
                end else begin
                    res.kind = K_END; res.status = ST_CANCEL; last = 1'b1;
                end
            end
            A_ABORT, A_LARGE, A_ERRORS: begin
                if (r_sub == 2'd2) begin
                    res.kind = K_END;
                    res.status = (i_cmd.act == A_ABORT) ? ST_ABORT :
                                 (i_cmd.act == A_LARGE) ? ST_LARGE : ST_ERRORS;
                    res.amount = (i_cmd.act == A_LARGE) ? i_cmd.amt : 32'd0;
                    last = 1'b1;
                end else begin
                    res.kind = K_SEND; res.tx_byte = B_CA;
                end
            end
            A_STAGE: begin
                res.kind = K_STAGE; res.tx_byte = i_cmd.data; res.address = i_cmd.addr;
                last = 1'b1;
            end
            A_NAK: begin
                res.kind = K_SEND; res.tx_byte = B_NAK; last = 1'b1;
            end
            A_EMPTY: begin
                if (r_sub == 2'd0) begin
                    res.kind = K_SEND; res.tx_byte = B_ACK;
                end else begin
                    res.kind = K_END; res.status = ST_DONE; res.amount = i_cmd.amt;
                    last = 1'b1;
                end
            end
            A_ERASE: begin
                if (r_sub == 2'd0) begin
                    res.kind = K_ERASE; res.address = i_cmd.addr; res.amount = i_cmd.amt;
                end else begin
                    res.kind = K_SEND;
                    res.tx_byte = (r_sub == 2'd1) ? B_ACK : B_C;
                    last = (r_sub == 2'd2);
                end
            end
            A_COMMIT: begin
                if (r_sub == 2'd0) begin
                    res.kind = K_COMMIT; res.address = i_cmd.addr; res.amount = i_cmd.amt;
                end else begin
                    res.kind = K_SEND; res.tx_byte = B_ACK; last = 1'b1;
                end
            end
            default: last = 1'b1;
        endcase
        res.last = last;
        n_sub = last ? 2'd0 : r_sub + 2'd1;
    end

    assign o_cmd_pop = i_cmd_valid && load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
            r_vld <= 1'b0;
        end else begin
            if (load) r_vld <= i_cmd_valid;
            if (i_cmd_valid && load) r_sub <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= res;
    end

endmodule

FILE: design/ymodem_crc_receiver.sv
// Top level of the YMODEM-CRC receiver.
//
// Input channel: push an event (req_type, rx_byte) while full is low; one
// event can be taken every cycle. Results come out as a queue: while empty
// is low the oldest result is on the o_ ports and pop takes it. One event
// gives zero to three results; the last has o_last set.
// Configuration: index 0 size limit, 1 flash base, 2 error limit; writes are
// always ready and belong between sessions, with nothing in flight.
// A result reaches the ports through the front register, the command queue and
// the output register.
// Throughput: the front takes one event per cycle while full is low and the back
// emits one result per cycle while results are popped, so events with one result
// or none run at one per cycle; an event with several results keeps the back busy.
// full is high while the command queue holds two or more commands. When the
// result side stalls, commands collect in the queue and push is refused;
// nothing is lost.
// Reset clears the session (idle) and loads the register defaults:
// size limit 65536, flash base 0, error limit 5.
module ymodem_crc_receiver import ymcr_pkg::*; #(
    parameter int unsigned SIZE_DIGITS_MAX = SIZE_DIGITS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_address,
    output logic [31:0] o_amount,
    output logic [2:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_size_lim, r_base;
    logic [7:0] r_err_lim;
    logic fr_valid;
    t_cmd fr_cmd;
    logic q_empty, q_pop;
    t_cmd q_data;
    logic [$clog2(QUEUE_DEPTH):0] q_count;
    logic res_valid;
    t_res res;
    logic accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_lim <= SIZE_LIMIT_RST;
            r_base <= FLASH_BASE_RST;
            r_err_lim <= ERROR_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_LIMIT: r_size_lim <= i_cfg_data;
                CFG_FLASH_BASE: r_base <= i_cfg_data;
                CFG_ERROR_LIMIT: r_err_lim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Leave room for the command still in the front register.
    assign full = (q_count >= ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH - 2));
    assign accept = push && !full;

    ymcr_front #(.SIZE_DIGITS_MAX(SIZE_DIGITS_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_req_type(i_req_type), .i_rx_byte(i_rx_byte),
        .i_size_limit(r_size_lim), .i_flash_base(r_base),
        .i_error_limit(r_err_lim), .o_cmd_valid(fr_valid), .o_cmd(fr_cmd)
    );

    ymcr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fr_valid), .i_data(fr_cmd),
        .i_pop(q_pop), .o_empty(q_empty), .o_count(q_count), .o_data(q_data)
    );

    ymcr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(!q_empty), .i_cmd(q_data),
        .o_cmd_pop(q_pop), .o_res_valid(res_valid), .o_res(res), .i_res_pop(pop)
    );

    assign empty = !res_valid;
    assign o_kind = res.kind;
    assign o_tx_byte = res.tx_byte;
    assign o_address = res.address;
    assign o_amount = res.amount;
    assign o_status = res.status;
    assign o_last = res.last;

endmodule

FILE: design/ymcr_checker.sv
// Port-level checker for the YMODEM-CRC receiver, bound to the top level.
module ymcr_checker import ymcr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [2:0] o_kind,
    input logic [2:0] o_status,
    input logic       o_last
);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == K_END) |-> o_last) else $error("end not last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != K_END) |-> (o_status == ST_DONE)) else $error("stray status");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind <= K_END)) else $error("bad kind");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind))) else $error("result dropped");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("not clear after reset");

endmodule

bind ymodem_crc_receiver ymcr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty),
    .pop(pop), .o_kind(o_kind), .o_status(o_status), .o_last(o_last)
);

FILE: verif/ymodem_crc_receiver_tb.sv
// Self-checking testbench for the YMODEM-CRC receiver: sessions, packets and register settings.
module ymodem_crc_receiver_tb;
    import ymcr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicts the receiver's results and checks what the block delivers.
    class ymodem_scoreboard;
        logic [31:0] size_cap, base_addr;
        logic [7:0]  err_limit;
        t_phase      phase;
        int unsigned idx, parse_stage, digits;
        bit          long_pkt, seq_ok, name_done, started, name_seen;
        logic [7:0]  seq, pkts, errs;
        logic [15:0] crc_run, crc_rx;
        logic [31:0] waddr, fsize, size_acc;
        t_res        step_out[$];
        t_res        pending[$];
        int          errors;

        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
            logic [15:0] v;
            v = c ^ {b, 8'h00};
            repeat (8) v = v[15] ? {v[14:0], 1'b0} ^ 16'h1021 : {v[14:0], 1'b0};
            return v;
        endfunction

        function void clear_session();
            phase = PH_IDLE; idx = 0; parse_stage = 0; digits = 0;
            long_pkt = 0; seq_ok = 0; name_done = 0; started = 0; name_seen = 0;
            seq = 0; pkts = 0; errs = 0; crc_run = 0; crc_rx = 0;
            waddr = 0; fsize = 0; size_acc = 0;
        endfunction

        function void reset();
            size_cap = SIZE_LIMIT_RST; base_addr = FLASH_BASE_RST;
            err_limit = ERROR_LIMIT_RST; errors = 0;
            clear_session();
        endfunction

        function void set_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                CFG_SIZE_LIMIT: size_cap = data;
                CFG_FLASH_BASE: base_addr = data;
                CFG_ERROR_LIMIT: err_limit = data[7:0];
                default: ;
            endcase
        endfunction

        function void emit(logic [2:0] kind, logic [7:0] tx, logic [31:0] addr,
                           logic [31:0] amt, logic [2:0] st);
            t_res r;
            r.kind = kind; r.tx_byte = tx; r.address = addr;
            r.amount = amt; r.status = st; r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        function void send_byte(logic [7:0] b);
            emit(K_SEND, b, 0, 0, ST_DONE);
        endfunction

        function void end_session(logic [2:0] st, logic [31:0] amt);
            emit(K_END, 0, 0, amt, st);
            phase = PH_IDLE;
        endfunction

        function void cancel(logic [2:0] st, logic [31:0] amt);
            send_byte(B_CA); send_byte(B_CA);
            end_session(st, amt);
        endfunction

        function void on_error();
            if (started && errs != 8'hff) errs++;
            if (errs > err_limit) begin
                cancel(ST_ERRORS, 0);
            end else begin
                send_byte(B_C);
                phase = PH_HEAD;
            end
        endfunction

        function void parse_name(logic [7:0] b, int unsigned p);
            logic [63:0] v;
            if (p == 0) name_seen = (b != 0);
            if (parse_stage == 0) begin
                if (b == 0) parse_stage = 1;
            end else if (parse_stage == 1) begin
                if (b == 8'h20 || digits >= SIZE_DIGITS_MAX_DEF || b < 8'h30 || b > 8'h39) begin
                    parse_stage = 2;
                end else begin
                    digits++;
                    v = 64'(size_acc) * 10 + 64'(b - 8'h30);
                    size_acc = (v > 64'hffff_ffff) ? 32'hffff_ffff : v[31:0];
                end
            end
        endfunction

        function void packet_end(logic [31:0] len);
            if (!seq_ok || crc_run != crc_rx) begin
                on_error();
                return;
            end
            errs = 0;
            phase = PH_HEAD;
            if (seq != pkts) begin
                send_byte(B_NAK);
                return;
            end
            if (!name_done) begin
                if (!name_seen) begin
                    send_byte(B_ACK);
                    end_session(ST_DONE, fsize);
                    return;
                end
                fsize = size_acc;
                if (fsize > size_cap) begin
                    cancel(ST_LARGE, fsize);
                    return;
                end
                emit(K_ERASE, 0, waddr, fsize, ST_DONE);
                send_byte(B_ACK); send_byte(B_C);
                name_done = 1;
            end else begin
                emit(K_COMMIT, 0, waddr, len, ST_DONE);
                waddr += len;
                send_byte(B_ACK);
            end
            pkts++;
            started = 1;
        endfunction

        function void body_byte(logic [7:0] b);
            int unsigned len;
            len = long_pkt ? LONG_PAYLOAD : SHORT_PAYLOAD;
            if (idx == 0) begin
                seq = b;
            end else if (idx == 1) begin
                seq_ok = (b == ~seq);
            end else if (idx < 2 + len) begin
                crc_run = crc_next(crc_run, b);
                if (name_done) emit(K_STAGE, b, waddr + (idx - 2), 0, ST_DONE);
                else parse_name(b, idx - 2);
            end else if (idx == 2 + len) begin
                crc_rx = {b, 8'h00};
            end else begin
                crc_rx[7:0] = b;
                packet_end(len);
                return;
            end
            idx++;
        endfunction

        function void head_byte(logic [7:0] b);
            if (b == B_SOH || b == B_STX) begin
                long_pkt = (b == B_STX);
                idx = 0; crc_run = 0; crc_rx = 0; seq_ok = 0;
                parse_stage = 0; digits = 0; size_acc = 0; name_seen = 0;
                phase = PH_BODY;
            end else if (b == B_EOT) begin
                errs = 0;
                send_byte(B_ACK); send_byte(B_C);
                pkts = 0; name_done = 0;
            end else if (b == B_CA) begin
                phase = PH_CA2;
            end else if (b == B_ETX || b == B_AB1 || b == B_AB2) begin
                cancel(ST_ABORT, 0);
            end else begin
                on_error();
            end
        endfunction

        // Note an accepted event and queue the results it causes.
        function void note_input(logic [1:0] req, logic [7:0] b);
            step_out.delete();
            if (req == REQ_START) begin
                clear_session();
                waddr = base_addr;
                phase = PH_HEAD;
                send_byte(B_C);
            end else if (req == REQ_TIMEOUT) begin
                if (phase != PH_IDLE) on_error();
            end else if (req == REQ_BYTE) begin
                case (phase)
                    PH_HEAD: head_byte(b);
                    PH_CA2: begin
                        if (b == B_CA) begin
                            send_byte(B_ACK);
                            end_session(ST_CANCEL, 0);
                        end else begin
                            on_error();
                        end
                    end
                    PH_BODY: body_byte(b);
                    default: ;
                endcase
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        function void check(t_res got);
            t_res exp_r;
            bit bad;
            bad = 0;
            if (pending.size() == 0) begin
                $error("unexpected result: kind %0d tx_byte %0h", got.kind, got.tx_byte);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind) begin
                $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); bad = 1;
            end
            if (got.tx_byte !== exp_r.tx_byte) begin
                $error("tx_byte: expected %0h, got %0h", exp_r.tx_byte, got.tx_byte); bad = 1;
            end
            if (got.address !== exp_r.address) begin
                $error("address: expected %0h, got %0h", exp_r.address, got.address); bad = 1;
            end
            if (got.amount !== exp_r.amount) begin
                $error("amount: expected %0d, got %0d", exp_r.amount, got.amount); bad = 1;
            end
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status); bad = 1;
            end
            if (got.last !== exp_r.last) begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last); bad = 1;
            end
            if (bad) errors++;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        pop = 0;
    logic [1:0]  i_req_type = REQ_BYTE;
    logic [7:0]  i_rx_byte = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = CFG_SIZE_LIMIT;
    logic [31:0] i_cfg_data = 0;
    logic        full, empty, o_cfg_ready, o_last;
    logic [2:0]  o_kind, o_status;
    logic [7:0]  o_tx_byte;
    logic [31:0] o_address, o_amount;

    ymodem_scoreboard sb;
    bit send_quiet = 0;
    bit recv_quiet = 0;
    bit hold_req = 0;
    int rand_events = 0;

    ymodem_crc_receiver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_req_type(i_req_type), .i_rx_byte(i_rx_byte),
        .empty(empty), .pop(pop),
        .o_kind(o_kind), .o_tx_byte(o_tx_byte), .o_address(o_address),
        .o_amount(o_amount), .o_status(o_status), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Draw a random idle gap; quiet mode mostly picks no gap.
    function automatic int draw_gap(bit quiet);
        if (quiet && $urandom_range(0, 9) != 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int gap;
        t_res r;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                pop <= 0;
                repeat (400) @(posedge i_clk);
            end
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            @(negedge i_clk);
            while (empty) @(negedge i_clk);
            r.kind = o_kind; r.tx_byte = o_tx_byte; r.address = o_address;
            r.amount = o_amount; r.status = o_status; r.last = o_last;
            @(posedge i_clk);
            sb.check(r);
        end
    end

    task automatic push_event(logic [1:0] req, logic [7:0] b);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_req_type <= req;
        i_rx_byte <= b;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_input(req, b);
        rand_events++;
    endtask

    task automatic push_byte(logic [7:0] b);
        push_event(REQ_BYTE, b);
    endtask

    // Hold the input until every expected result is in, then let the block drain.
    task automatic drain();
        int n;
        n = 0;
        push <= 0;
        while (sb.pending.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.set_reg(index, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // Send one framed packet; corrupt selects: 0 good, 1 bad complement, 2 bad CRC,
    // 3 cut short by a timeout.
    task automatic send_packet(bit lng, logic [7:0] seq, logic [7:0] pl[], int corrupt);
        logic [15:0] crc;
        int cut;
        crc = 0;
        foreach (pl[i]) crc = ymodem_scoreboard::crc_next(crc, pl[i]);
        if (corrupt == 2) crc ^= 16'(1 << $urandom_range(0, 15));
        cut = (corrupt == 3) ? $urandom_range(0, 15) : pl.size();
        push_byte(lng ? B_STX : B_SOH);
        push_byte(seq);
        push_byte(corrupt == 1 ? ~seq ^ 8'(1 << $urandom_range(0, 7)) : ~seq);
        for (int i = 0; i < cut; i++) push_byte(pl[i]);
        if (corrupt == 3) begin
            push_event(REQ_TIMEOUT, 8'($urandom));
            return;
        end
        push_byte(crc[15:8]);
        push_byte(crc[7:0]);
    endtask

    // Build a filename payload; sizing selects how the size field looks.
    function automatic void make_name(ref logic [7:0] pl[], input bit lng, input int sizing);
        string num;
        int nlen, pos;
        logic [63:0] v;
        pl = new[lng ? LONG_PAYLOAD : SHORT_PAYLOAD];
        foreach (pl[i]) pl[i] = 0;
        if (sizing == 0) return;  // empty name closes the session
        nlen = $urandom_range(1, 12);
        for (int i = 0; i < nlen; i++) pl[i] = 8'($urandom_range(33, 126));
        if (sizing == 4) begin
            // no terminator at all
            foreach (pl[i]) pl[i] = 8'($urandom_range(1, 255));
            return;
        end
        case (sizing)
            1: begin
                v = (sb.size_cap > 200000) ? $urandom_range(0, 200000)
                                           : $urandom_range(0, sb.size_cap);
                num = $sformatf("%0d", v);
            end
            2: num = $sformatf("%0d", $urandom);
            3: num = "99999999999999999999";
            default: num = "";
        endcase
        pos = nlen + 1;
        for (int j = 0; j < num.len(); j++) pl[pos + j] = num[j];
        pos += num.len();
        pl[pos] = ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(58, 255));
        for (int i = pos + 1; i < pl.size(); i++)
            pl[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    endfunction

    task automatic random_session();
        logic [7:0] pl[];
        int npk, pick, corrupt;
        bit lng;
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
        push_event(REQ_START, 8'($urandom));
        // occasional noise in the header phase
        if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: push_event(REQ_TIMEOUT, 0);
                1: push_byte(8'($urandom_range(5, 23)));
                2: push_event(REQ_UNUSED, 8'($urandom));
                default: begin push_byte(B_CA); push_byte(8'($urandom_range(0, 23))); end
            endcase
            if (sb.phase == PH_IDLE) return;
        end
        // long packets are only started and cut short
        if ($urandom_range(0, 1) == 0) begin
            make_name(pl, 1, 1);
            send_packet(1, sb.pkts, pl, 3);
            if (sb.phase == PH_IDLE) return;
        end
        // filename packet, at random sent again while corrupted
        do begin
            pick = $urandom_range(0, 19);
            make_name(pl, 0, pick < 13 ? 1 : pick < 15 ? 2 : pick < 17 ? 3 :
                             pick < 18 ? 4 : pick < 19 ? 5 : 0);
            corrupt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            send_packet(0, sb.pkts, pl, corrupt);
            if (sb.phase == PH_IDLE) return;
        end while (corrupt != 0 && $urandom_range(0, 1) == 0);
        npk = (rand_events < 120) ? $urandom_range(0, 1) : 0;
        for (int k = 0; k < npk; k++) begin
            pl = new[SHORT_PAYLOAD];
            foreach (pl[i]) pl[i] = 8'($urandom);
            pick = $urandom_range(0, 9);
            corrupt = (pick < 6) ? 0 : $urandom_range(1, 3);
            send_packet(0, (pick == 9) ? sb.pkts - 8'd1 : sb.pkts, pl, corrupt);
            if (sb.phase == PH_IDLE) return;
        end
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            push_byte(B_EOT);
            if (rand_events < 150) begin
                make_name(pl, 0, 0);
                send_packet(0, 0, pl, 0);
            end
        end else if (pick < 15) begin
            push_byte(B_CA);
            push_byte(B_CA);
        end else if (pick < 17) begin
            push_byte((pick == 15) ? B_AB1 : B_ETX);
        end else begin
            // error storm; needs a finished packet before errors count
            for (int i = 0; i < 12 && sb.phase != PH_IDLE; i++)
                push_event(REQ_TIMEOUT, 8'($urandom));
        end
        // one more byte after the end; it is ignored if the session has closed
        push_byte(8'($urandom));
    endtask

    initial begin
        int sess;
        sb = new();
        sb.reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: idle inputs, header errors and EOT, cancel and abort paths
        push_byte(8'hff);
        push_event(REQ_TIMEOUT, 8'h00);
        push_event(REQ_UNUSED, 8'haa);
        push_event(REQ_START, 8'h55);
        push_event(REQ_TIMEOUT, 8'h00);
        push_byte(8'hff);
        push_byte(B_CA);
        push_byte(8'h00);
        push_byte(B_EOT);
        push_byte(B_AB1);
        push_event(REQ_START, 0);
        push_byte(B_AB2);
        push_event(REQ_START, 0);
        push_byte(B_ETX);
        push_event(REQ_START, 0);
        push_byte(B_CA);
        push_byte(B_CA);
        push_byte(8'h7f);
        drain();

        sess = 0;
        while (rand_events < 240) begin
            case (sess % 4)
                0: begin
                    write_reg(CFG_SIZE_LIMIT, 32'hffff_ffff);
                    write_reg(CFG_FLASH_BASE, 32'hffff_ff80);
                    write_reg(CFG_ERROR_LIMIT, 8'd0);
                end
                1: begin
                    write_reg(CFG_SIZE_LIMIT, $urandom_range(1, 300000));
                    write_reg(CFG_FLASH_BASE, $urandom);
                    write_reg(CFG_ERROR_LIMIT, $urandom_range(1, 8));
                end
                2: begin
                    write_reg(CFG_SIZE_LIMIT, 32'd0);
                    write_reg(CFG_FLASH_BASE, $urandom);
                    write_reg(CFG_ERROR_LIMIT, 8'd255);
                end
                default: begin
                    write_reg(CFG_SIZE_LIMIT, SIZE_LIMIT_RST);
                    write_reg(CFG_FLASH_BASE, FLASH_BASE_RST);
                    write_reg(CFG_ERROR_LIMIT, ERROR_LIMIT_RST);
                end
            endcase
            if (sess == 0) hold_req = 1;
            random_session();
            drain();
            sess++;
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d expected results never arrived", sb.pending.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
